>>> hdl/ate_pkg.sv
package ate_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int FUNC_W  = 4;
    localparam int POS_W   = 5;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 3;
    localparam int FPOS_W  = 4;
    localparam int CNT_W   = 5;
    localparam int CFG_W   = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef enum logic [FUNC_W-1:0] {
        F_APPEND   = 4'd0,
        F_INSERT   = 4'd1,
        F_DELETE   = 4'd2,
        F_LSEARCH  = 4'd3,
        F_BSEARCH  = 4'd4,
        F_REVERSE  = 4'd5,
        F_SINSERT  = 4'd6,
        F_STEST    = 4'd7,
        F_DUMP     = 4'd8
    } t_func;

    localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd4;

    // command handed from the front end to the back end
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] value;
    } t_cmd;

endpackage

>>> hdl/ate_front.sv
module ate_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [3:0]     i_func,
    input  logic [4:0]     i_position,
    input  logic [31:0]    i_item_value,
    output logic           o_q_valid,
    input  logic           i_q_pop,
    output ate_pkg::t_cmd  o_q_cmd
);
    import ate_pkg::*;

    // two-entry command queue
    t_cmd     r_mem [2];
    logic     r_wp, r_rp;
    logic [1:0] r_cnt;
    logic     push;

    assign o_stall   = (r_cnt == 2'd2);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{func: i_func, position: i_position, value: i_item_value};
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

>>> hdl/ate_back.sv
module ate_back #(
    parameter int CAPACITY = ate_pkg::CAPACITY_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [4:0]    i_limit,
    input  logic          i_q_valid,
    output logic          o_q_pop,
    input  ate_pkg::t_cmd i_q_cmd,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [2:0]    o_status,
    output logic [3:0]    o_found_position,
    output logic [31:0]   o_result_value,
    output logic [4:0]    o_fill_count,
    output logic          o_is_sorted,
    output logic          o_last
);
    import ate_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int IW = AW + 2;
    localparam logic signed [IW-1:0] I_ONE = IW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_EXEC, S_OUT
    } t_state;

    logic [DATA_W-1:0] r_mem [CAPACITY];
    logic [DATA_W-1:0] r_rdata;
    logic [AW-1:0]     n_raddr;
    logic              n_rd;
    logic              n_we;
    logic [AW-1:0]     n_waddr;
    logic [DATA_W-1:0] n_wdata;

    t_state r_state, n_state;
    t_cmd   r_cmd, n_cmd;
    logic [CNT_W-1:0] r_count, n_count;
    logic signed [IW-1:0] r_i, n_i, r_j, n_j;
    logic [DATA_W-1:0] r_tmp, n_tmp;
    logic [1:0] r_ph, n_ph;
    logic r_vld, n_vld;
    logic [STAT_W-1:0] r_st, n_st;
    logic [FPOS_W-1:0] r_fp, n_fp;
    logic [DATA_W-1:0] r_rv, n_rv;
    logic r_srt, n_srt, r_last, n_last;
    logic [CNT_W-1:0] r_fc, n_fc;

    logic [CNT_W:0] lim;
    logic full;
    logic out_free;
    logic signed [IW-1:0] cnt_s, mid;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_waddr] <= n_wdata;
        if (n_rd) r_rdata <= r_mem[n_raddr];
    end

    assign lim   = ({1'b0, i_limit} < (CNT_W+1)'(CAPACITY)) ? {1'b0, i_limit}
                                                           : (CNT_W+1)'(CAPACITY);
    assign full  = {1'b0, r_count} >= lim;
    assign out_free = !r_vld || !i_stall;
    assign cnt_s = IW'(r_count);
    assign mid   = (r_i + r_j) >>> 1;
    // hold the next command until the previous result has left
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && out_free;

    always_comb begin
        n_state = r_state; n_cmd = r_cmd; n_count = r_count;
        n_i = r_i; n_j = r_j; n_tmp = r_tmp; n_ph = r_ph;
        n_vld = r_vld && i_stall;
        n_st = r_st; n_fp = r_fp; n_rv = r_rv; n_srt = r_srt;
        n_last = r_last; n_fc = r_fc;
        n_rd = 1'b0; n_raddr = '0; n_we = 1'b0; n_waddr = '0; n_wdata = '0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    n_cmd = i_q_cmd;
                    n_state = S_RD;
                    n_ph = 2'd0;
                    n_i = '0;
                    n_j = '0;
                end
            end
            S_RD: begin
                // per-op setup
                n_state = S_EXEC;
                n_st = ST_OK; n_fp = '0; n_rv = '0; n_srt = 1'b0; n_last = 1'b1;
                case (r_cmd.func)
                    F_APPEND: begin
                        if (full) n_st = ST_FULL;
                        else begin
                            n_we = 1'b1; n_waddr = AW'(r_count);
                            n_wdata = r_cmd.value;
                            n_count = r_count + 1'b1;
                        end
                        n_state = S_OUT;
                    end
                    F_INSERT: begin
                        if (full) begin n_st = ST_FULL; n_state = S_OUT; end
                        else if (r_cmd.position > r_count) begin
                            n_st = ST_BADPOS; n_state = S_OUT;
                        end else n_i = cnt_s;
                    end
                    F_DELETE: begin
                        if (r_count == '0) begin n_st = ST_EMPTY; n_state = S_OUT; end
                        else if (r_cmd.position >= r_count) begin
                            n_st = ST_BADPOS; n_state = S_OUT;
                        end else n_i = IW'(r_cmd.position);
                    end
                    F_LSEARCH: n_i = '0;
                    F_BSEARCH: begin n_i = '0; n_j = cnt_s - I_ONE; end
                    F_REVERSE: begin n_i = '0; n_j = cnt_s - I_ONE; end
                    F_SINSERT: begin
                        if (full) begin n_st = ST_FULL; n_state = S_OUT; end
                        else n_i = cnt_s;
                    end
                    F_STEST: begin n_i = '0; n_srt = 1'b1; end
                    F_DUMP: begin
                        if (r_count == '0) begin n_st = ST_EMPTY; n_state = S_OUT; end
                        else n_i = '0;
                    end
                    default: n_state = S_OUT;
                endcase
                if (n_state == S_OUT) n_fc = n_count;
            end
            S_EXEC: begin
                // ph 0: issue read, ph 1: wait, ph 2: use data
                if (r_ph == 2'd0) begin
                    n_ph = 2'd1;
                    n_rd = 1'b1;
                    case (r_cmd.func)
                        F_INSERT, F_SINSERT: begin
                            if (r_i == 0 || (r_cmd.func == F_INSERT
                                             && r_i == IW'(r_cmd.position))) begin
                                n_rd = 1'b0;
                                n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_cmd.value;
                                n_count = r_count + 1'b1; n_fc = n_count;
                                n_state = S_OUT; n_ph = 2'd0;
                            end else n_raddr = AW'(r_i - I_ONE);
                        end
                        F_DELETE: begin
                            n_raddr = AW'(r_i);
                            if (r_i + I_ONE >= cnt_s && r_i != IW'(r_cmd.position)) begin
                                n_rd = 1'b0;
                                n_count = r_count - 1'b1; n_fc = n_count;
                                n_state = S_OUT; n_ph = 2'd0;
                            end
                        end
                        F_LSEARCH: begin
                            n_raddr = AW'(r_i);
                            if (r_i >= cnt_s) begin
                                n_rd = 1'b0; n_st = ST_NOTFOUND; n_fc = r_count;
                                n_state = S_OUT; n_ph = 2'd0;
                            end
                        end
                        F_BSEARCH: begin
                            n_raddr = AW'(mid);
                            if (r_i > r_j) begin
                                n_rd = 1'b0; n_st = ST_NOTFOUND; n_fc = r_count;
                                n_state = S_OUT; n_ph = 2'd0;
                            end
                        end
                        F_REVERSE: begin
                            n_raddr = AW'(r_i);
                            if (r_i >= r_j) begin
                                n_rd = 1'b0; n_fc = r_count;
                                n_state = S_OUT; n_ph = 2'd0;
                            end
                        end
                        F_STEST: begin
                            n_raddr = AW'(r_i);
                            if (r_i + I_ONE >= cnt_s) begin
                                n_rd = 1'b0; n_fc = r_count;
                                n_state = S_OUT; n_ph = 2'd0;
                            end
                        end
                        F_DUMP: begin
                            n_raddr = AW'(r_i);
                            if (r_i >= cnt_s) begin
                                n_rd = 1'b0; n_state = S_IDLE; n_ph = 2'd0;
                            end
                        end
                        default: begin n_rd = 1'b0; n_state = S_OUT; n_ph = 2'd0; end
                    endcase
                end else if (r_ph == 2'd1) begin
                    n_ph = 2'd2;
                    // reverse, sorted test and delete need a second entry
                    if (r_cmd.func == F_REVERSE) begin
                        n_rd = 1'b1; n_raddr = AW'(r_j);
                    end else if (r_cmd.func == F_STEST) begin
                        n_rd = 1'b1; n_raddr = AW'(r_i + I_ONE);
                    end else if (r_cmd.func == F_DELETE) begin
                        n_rd = 1'b1; n_raddr = AW'(r_i + I_ONE);
                    end
                    n_tmp = r_rdata;
                end else begin
                    n_ph = 2'd0;
                    case (r_cmd.func)
                        F_INSERT: begin
                            n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_tmp;
                            n_i = r_i - I_ONE;
                        end
                        F_SINSERT: begin
                            if ($signed(r_tmp) > $signed(r_cmd.value)) begin
                                n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_tmp;
                                n_i = r_i - I_ONE;
                            end else begin
                                n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_cmd.value;
                                n_count = r_count + 1'b1; n_fc = n_count;
                                n_state = S_OUT;
                            end
                        end
                        F_DELETE: begin
                            if (r_i == IW'(r_cmd.position)) n_rv = r_tmp;
                            if (r_i + I_ONE < cnt_s) begin
                                n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_rdata;
                            end
                            n_i = r_i + I_ONE;
                        end
                        F_LSEARCH: begin
                            if (r_tmp == r_cmd.value) begin
                                n_fp = FPOS_W'(r_i); n_fc = r_count; n_state = S_OUT;
                            end else n_i = r_i + I_ONE;
                        end
                        F_BSEARCH: begin
                            if (r_tmp == r_cmd.value) begin
                                n_fp = FPOS_W'(mid); n_fc = r_count; n_state = S_OUT;
                            end else if ($signed(r_tmp) > $signed(r_cmd.value))
                                n_j = mid - I_ONE;
                            else n_i = mid + I_ONE;
                        end
                        F_REVERSE: begin
                            // swap with two writes: b now, a via S_WAIT
                            n_we = 1'b1; n_waddr = AW'(r_j); n_wdata = r_tmp;
                            n_tmp = r_rdata;
                            n_state = S_WAIT;
                        end
                        F_STEST: begin
                            if ($signed(r_tmp) > $signed(r_rdata)) begin
                                n_srt = 1'b0; n_fc = r_count; n_state = S_OUT;
                            end else n_i = r_i + I_ONE;
                        end
                        F_DUMP: begin
                            if (out_free) begin
                                n_vld = 1'b1; n_st = ST_OK; n_fp = FPOS_W'(r_i);
                                n_rv = r_tmp; n_fc = r_count; n_srt = 1'b0;
                                n_last = (r_i + I_ONE == cnt_s);
                                n_i = r_i + I_ONE;
                            end else n_ph = 2'd2;
                        end
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_WAIT: begin
                n_we = 1'b1; n_waddr = AW'(r_i); n_wdata = r_tmp;
                n_i = r_i + I_ONE; n_j = r_j - I_ONE;
                n_state = S_EXEC;
            end
            S_OUT: begin
                if (out_free) begin
                    n_vld = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd; r_i <= n_i; r_j <= n_j; r_tmp <= n_tmp;
        r_st <= n_st; r_fp <= n_fp; r_rv <= n_rv; r_srt <= n_srt;
        r_last <= n_last; r_fc <= n_fc;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_vld <= 1'b0; r_ph <= 2'd0;
        end else begin
            r_state <= n_state; r_count <= n_count; r_vld <= n_vld; r_ph <= n_ph;
        end
    end

    assign o_valid = r_vld;
    assign o_status = r_st;
    assign o_found_position = r_fp;
    assign o_result_value = r_rv;
    assign o_fill_count = r_fc;
    assign o_is_sorted = r_srt;
    assign o_last = r_last;
endmodule

>>> hdl/array_table_engine.sv
// Table of signed 32-bit entries with a fill count, driven by one command per
// input transfer. A two-entry command queue in front lets inputs be taken
// while the back end works. The back end owns a single-port RAM with a
// registered read and walks it one entry per access: each step issues a read,
// takes the registered data and then uses it, for shifts, scans, the sorted
// test, reverse and binary search alike; a dump gives one result per entry and
// waits while the receiver stalls. Append and flagged errors need no table walk.
// The back end starts a new command only once the previous result is taken.
module array_table_engine #(
    parameter int CAPACITY = ate_pkg::CAPACITY_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [3:0]  i_func,
    input  logic [4:0]  i_position,
    input  logic [31:0] i_item_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [3:0]  o_found_position,
    output logic [31:0] o_result_value,
    output logic [4:0]  o_fill_count,
    output logic        o_is_sorted,
    output logic        o_last
);
    import ate_pkg::*;

    logic [CFG_W-1:0] r_limit;
    logic q_valid, q_pop;
    t_cmd q_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= CFG_RESET;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    ate_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_func, .i_position, .i_item_value,
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_cmd(q_cmd)
    );

    ate_back #(.CAPACITY(CAPACITY)) u_back (
        .i_clk, .i_rst_n, .i_limit(r_limit),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_cmd(q_cmd),
        .o_valid, .i_stall, .o_status, .o_found_position, .o_result_value,
        .o_fill_count, .o_is_sorted, .o_last
    );

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_fill_count <= 5'(CAPACITY))
        else $error("fill count above capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value) && $stable(o_last))
        else $error("stalled result changed");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
    import ate_pkg::*;

    localparam int TBL_DEPTH   = 16;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  fpos;
        logic [31:0] value;
        logic [4:0]  fill;
        logic        sorted;
        logic        last;
    } t_res;

    typedef struct {
        logic [3:0]  func;
        logic [4:0]  position;
        logic [31:0] value;
        bit          has_exp;
        t_res        exp;
    } t_row;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [4:0]  cfg_wdata = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [3:0]  in_func = '0;
    logic [4:0]  in_pos = '0;
    logic [31:0] in_val = '0;
    logic        out_valid;
    logic        out_stall = 1;
    logic [2:0]  o_status;
    logic [3:0]  o_fpos;
    logic [31:0] o_value;
    logic [4:0]  o_fill;
    logic        o_sorted;
    logic        o_last;

    array_table_engine i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_func(in_func), .i_position(in_pos), .i_item_value(in_val),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(o_status), .o_found_position(o_fpos), .o_result_value(o_value),
        .o_fill_count(o_fill), .o_is_sorted(o_sorted), .o_last(o_last)
    );

    // model copy of the table
    logic signed [31:0] tbl [TBL_DEPTH];
    int                 tbl_cnt;
    int                 cap_lim;
    t_res               pending_q[$];
    int                 errors = 0;
    int                 cycles = 0;
    bit                 hold_off = 0;

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_res mk(logic [2:0] st, int p, logic [31:0] v, int s, int l);
        t_res r;
        r.status = st; r.fpos = p[3:0]; r.value = v; r.fill = tbl_cnt[4:0];
        r.sorted = s[0]; r.last = l[0];
        return r;
    endfunction

    // apply one command to the model table and queue its results
    task automatic table_apply(logic [3:0] f, logic [4:0] p, logic signed [31:0] v);
        int lim, i, lo, hi, mid, srt;
        logic signed [31:0] t;
        bit full;
        lim = cap_lim < TBL_DEPTH ? cap_lim : TBL_DEPTH;
        full = tbl_cnt >= lim;
        case (f)
            F_APPEND, F_INSERT, F_SINSERT: begin
                if (full) pending_q.push_back(mk(ST_FULL, 0, 0, 0, 1));
                else if (f == F_INSERT && p > tbl_cnt)
                    pending_q.push_back(mk(ST_BADPOS, 0, 0, 0, 1));
                else begin
                    if (f == F_APPEND) i = tbl_cnt;
                    else begin
                        i = tbl_cnt;
                        while (f == F_INSERT ? i > p : (i > 0 && tbl[i-1] > v)) begin
                            tbl[i] = tbl[i-1];
                            i--;
                        end
                    end
                    tbl[i] = v;
                    tbl_cnt++;
                    pending_q.push_back(mk(ST_OK, 0, 0, 0, 1));
                end
            end
            F_DELETE: begin
                if (tbl_cnt == 0) pending_q.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
                else if (p >= tbl_cnt) pending_q.push_back(mk(ST_BADPOS, 0, 0, 0, 1));
                else begin
                    t = tbl[p];
                    for (i = p; i + 1 < tbl_cnt; i++) tbl[i] = tbl[i+1];
                    tbl_cnt--;
                    pending_q.push_back(mk(ST_OK, 0, t, 0, 1));
                end
            end
            F_LSEARCH: begin
                lo = -1;
                for (i = tbl_cnt - 1; i >= 0; i--) if (tbl[i] == v) lo = i;
                if (lo < 0) pending_q.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
                else pending_q.push_back(mk(ST_OK, lo, 0, 0, 1));
            end
            F_BSEARCH: begin
                lo = 0; hi = tbl_cnt - 1; mid = -1;
                while (lo <= hi) begin
                    mid = (lo + hi) / 2;
                    if (tbl[mid] == v) break;
                    if (tbl[mid] > v) hi = mid - 1;
                    else lo = mid + 1;
                    mid = -1;
                end
                if (mid < 0) pending_q.push_back(mk(ST_NOTFOUND, 0, 0, 0, 1));
                else pending_q.push_back(mk(ST_OK, mid, 0, 0, 1));
            end
            F_REVERSE: begin
                for (i = 0; i < tbl_cnt / 2; i++) begin
                    t = tbl[i];
                    tbl[i] = tbl[tbl_cnt-1-i];
                    tbl[tbl_cnt-1-i] = t;
                end
                pending_q.push_back(mk(ST_OK, 0, 0, 0, 1));
            end
            F_STEST: begin
                srt = 1;
                for (i = 0; i + 1 < tbl_cnt; i++) if (tbl[i] > tbl[i+1]) srt = 0;
                pending_q.push_back(mk(ST_OK, 0, 0, srt, 1));
            end
            F_DUMP: begin
                if (tbl_cnt == 0) pending_q.push_back(mk(ST_EMPTY, 0, 0, 0, 1));
                for (i = 0; i < tbl_cnt; i++)
                    pending_q.push_back(mk(ST_OK, i, tbl[i], 0, i + 1 == tbl_cnt));
            end
            default: pending_q.push_back(mk(ST_OK, 0, 0, 0, 1));
        endcase
    endtask

    // result checker
    always @(posedge clk) begin
        t_res e;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status); errors++;
                end
                if (o_fpos !== e.fpos) begin
                    $error("found_position exp %0d got %0d", e.fpos, o_fpos); errors++;
                end
                if (o_value !== e.value) begin
                    $error("result_value exp %h got %h", e.value, o_value); errors++;
                end
                if (o_fill !== e.fill) begin
                    $error("fill_count exp %0d got %0d", e.fill, o_fill); errors++;
                end
                if (o_sorted !== e.sorted) begin
                    $error("is_sorted exp %0d got %0d", e.sorted, o_sorted); errors++;
                end
                if (o_last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_last); errors++;
                end
            end
        end
    end

    // receiver stall: random gaps, or a long hold-off on request
    initial begin
        int w;
        @(posedge clk iff rst_n);
        forever begin
            if (hold_off) begin
                out_stall <= 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            if (w > 0) begin
                out_stall <= 1;
                repeat (w) @(posedge clk);
            end
            out_stall <= 0;
            @(posedge clk);
        end
    end

    task automatic send(logic [3:0] f, logic [4:0] p, logic [31:0] v, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 10) : 0;
        if (w > 0) begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1; in_func <= f; in_pos <= p; in_val <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        table_apply(f, p, v);
    endtask

    task automatic go_idle();
        in_valid <= 0;
        @(posedge clk);
        while (pending_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_limit(int l);
        cfg_we <= 1; cfg_wdata <= l[4:0];
        @(posedge clk);
        cfg_we <= 0;
        cap_lim = l;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 4))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 7) - 3;
            default: return $urandom;
        endcase
    endfunction

    t_row dir_rows[$];

    function automatic void add_row(logic [3:0] f, logic [4:0] p, logic [31:0] v,
                                    bit he, t_res e);
        t_row r;
        r.func = f; r.position = p; r.value = v; r.has_exp = he; r.exp = e;
        dir_rows.push_back(r);
    endfunction

    initial begin
        t_res none;
        t_res exp_row;
        int k, ph, n, f;
        none = '0;
        tbl_cnt = 0;
        cap_lim = 16;
        repeat (8) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed table: rows with results read off directly (empty table, first append), then rows left to the model
        add_row(F_DUMP,    0,  0, 1, '{ST_EMPTY, 0, 0, 0, 0, 1});
        add_row(F_DELETE,  0,  0, 1, '{ST_EMPTY, 0, 0, 0, 0, 1});
        add_row(F_LSEARCH, 0,  5, 1, '{ST_NOTFOUND, 0, 0, 0, 0, 1});
        add_row(F_BSEARCH, 0,  5, 1, '{ST_NOTFOUND, 0, 0, 0, 0, 1});
        add_row(F_STEST,   0,  0, 1, '{ST_OK, 0, 0, 0, 1, 1});
        add_row(F_INSERT,  1,  3, 1, '{ST_BADPOS, 0, 0, 0, 0, 1});
        add_row(4'd15,     31, 32'hffff_ffff, 1, '{ST_OK, 0, 0, 0, 0, 1});
        add_row(F_APPEND,  0,  32'h8000_0000, 1, '{ST_OK, 0, 0, 1, 0, 1});
        add_row(F_STEST,   0,  0, 1, '{ST_OK, 0, 0, 1, 1, 1});
        add_row(F_APPEND,  0,  32'h7fff_ffff, 0, none);
        add_row(F_INSERT,  1,  32'd7, 0, none);
        add_row(F_INSERT,  0,  32'hffff_fffe, 0, none);
        add_row(F_SINSERT, 0,  32'd0, 0, none);
        add_row(F_STEST,   0,  0, 0, none);
        add_row(F_REVERSE, 0,  0, 0, none);
        add_row(F_DUMP,    0,  0, 0, none);
        add_row(F_BSEARCH, 0,  32'd7, 0, none);
        add_row(F_LSEARCH, 0,  32'h7fff_ffff, 0, none);
        add_row(F_DELETE,  5,  0, 0, none);
        add_row(F_DELETE,  0,  0, 0, none);
        add_row(F_INSERT,  16, 1, 0, none);
        add_row(4'd9,      0,  0, 0, none);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_exp) begin
                exp_row = dir_rows[i].exp;
                send(dir_rows[i].func, dir_rows[i].position, dir_rows[i].value, 1);
                if (pending_q[$] !== exp_row) begin
                    $error("directed row %0d model disagrees with table", i);
                    errors++;
                end
            end else
                send(dir_rows[i].func, dir_rows[i].position, dir_rows[i].value, 1);
        end
        go_idle();

        // phases of random work at several capacity limits
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_limit(16);
                1: set_limit(0);
                2: set_limit(3);
                3: set_limit(31);
                4: set_limit(1);
                default: set_limit($urandom_range(4, 15));
            endcase
            n = ph == 1 || ph == 4 ? 25 : 65;
            for (k = 0; k < n; k++) begin
                if (ph == 0 && k == 20) hold_off = 1;
                f = $urandom_range(0, 99);
                if (f < 22) f = F_APPEND;
                else if (f < 32) f = F_SINSERT;
                else if (f < 42) f = F_INSERT;
                else if (f < 55) f = F_DELETE;
                else if (f < 63) f = F_LSEARCH;
                else if (f < 71) f = F_BSEARCH;
                else if (f < 77) f = F_REVERSE;
                else if (f < 84) f = F_STEST;
                else if (f < 94) f = F_DUMP;
                else f = $urandom_range(9, 15);
                send(f[3:0],
                     5'($urandom_range(0, 3) == 0 ? $urandom_range(0, 31)
                                                  : $urandom_range(0, tbl_cnt)),
                     (f == F_LSEARCH || f == F_BSEARCH) && tbl_cnt > 0 &&
                         $urandom_range(0, 1) ? tbl[$urandom_range(0, tbl_cnt - 1)]
                                              : rand_val(),
                     !(ph == 0 && k >= 20 && k < 40));
            end
            go_idle();
        end

        if (errors == 0 && pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
